[rtl/sbsr_pkg.sv]
// Package for the sprite blitter with background save and restore.
// Holds sizes, request kinds, register indexes and the request/result structs.
// No dependencies.
package sbsr_pkg;

	// Sizes of the stores
	localparam int MAX_SCREEN_WIDTH  = 256;
	localparam int MAX_SCREEN_HEIGHT = 256;
	localparam int MAX_SPRITE_SIDE   = 32;
	localparam int FB_DEPTH   = MAX_SCREEN_WIDTH * MAX_SCREEN_HEIGHT;
	localparam int SAVE_DEPTH = MAX_SPRITE_SIDE * MAX_SPRITE_SIDE;
	localparam int BITS_PER_BYTE = 8;
	localparam int MASK_DEPTH = (SAVE_DEPTH + BITS_PER_BYTE - 1) / BITS_PER_BYTE;
	localparam int FB_AW   = $clog2(FB_DEPTH);
	localparam int SAVE_AW = $clog2(SAVE_DEPTH);
	localparam int MASK_AW = $clog2(MASK_DEPTH);
	localparam int BYTE_SHIFT = $clog2(BITS_PER_BYTE);

	// Field and register widths
	localparam int KIND_W  = 3;
	localparam int COORD_W = 8;
	localparam int PIXEL_W = 32;
	localparam int MIDX_W  = 7;
	localparam int SCR_W   = 9;
	localparam int SPR_W   = 6;
	localparam int CFG_W   = 9;
	localparam int CFG_IDX_W = 2;
	localparam int PROD_W  = COORD_W + SCR_W;

	localparam logic [BITS_PER_BYTE-1:0] MASK_FIRST_BIT = 8'b1000_0000;

	// Request kinds
	localparam logic [KIND_W-1:0] KIND_LOAD  = 3'd0;
	localparam logic [KIND_W-1:0] KIND_DRAW  = 3'd1;
	localparam logic [KIND_W-1:0] KIND_CLEAR = 3'd2;
	localparam logic [KIND_W-1:0] KIND_WRITE = 3'd3;
	localparam logic [KIND_W-1:0] KIND_READ  = 3'd4;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SPRITE_WIDTH  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPRITE_HEIGHT = 2'd3;

	typedef struct packed {
		logic [KIND_W-1:0]        kind;
		logic [COORD_W-1:0]       x_coord;
		logic [COORD_W-1:0]       y_coord;
		logic [PIXEL_W-1:0]       color;
		logic [MIDX_W-1:0]        mask_index;
		logic [BITS_PER_BYTE-1:0] mask_byte;
	} req_t;

	typedef struct packed {
		logic [PIXEL_W-1:0] pixel_value;
		logic               out_of_range;
	} res_t;

endpackage

[rtl/sprite_blit_save_restore.sv]
// Top level of the sprite blitter: sequencer, config registers and four RAMs.
// Depends on sbsr_pkg and sbsr_ram.
//
// Channel   Direction  Handshake            Payload
// in        input      in_valid / in_stall  in_data  (sbsr_pkg::req_t)
// out       output     out_valid / out_stall out_data (sbsr_pkg::res_t)
// cfg       input      cfg_we               cfg_index, cfg_data
//
// Load mask and unknown kinds pass setup and result; write pixel adds an access
// state, read pixel an access and a read state; an off-screen write or read pixel
// goes from setup to result. Draw and clear walk the clipped sprite, if any of it
// is on screen, between setup and result: the walk steps one pixel per
// fetch/apply pair through the frame RAM port. After reset a clearing pass zeroes
// the framebuffer with in_stall held high. in_stall stays high until the result is
// in the output register; a request is taken while an earlier result still waits there.
module sprite_blit_save_restore (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  sbsr_pkg::req_t                      in_data,
	output logic                                out_valid,
	input  logic                                out_stall,
	output sbsr_pkg::res_t                      out_data,
	input  logic                                cfg_we,
	input  logic [sbsr_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [sbsr_pkg::CFG_W-1:0]          cfg_data
);

	typedef enum logic [7:0] {
		S_INIT   = 8'b0000_0001,
		S_IDLE   = 8'b0000_0010,
		S_SETUP  = 8'b0000_0100,
		S_ACCESS = 8'b0000_1000,
		S_READ   = 8'b0001_0000,
		S_FETCH  = 8'b0010_0000,
		S_APPLY  = 8'b0100_0000,
		S_RESULT = 8'b1000_0000
	} state_t;

	state_t state_q;

	// Config registers
	logic [sbsr_pkg::SCR_W-1:0] sw_q, sh_q;
	logic [sbsr_pkg::SPR_W-1:0] pw_q, ph_q;
	logic [sbsr_pkg::SCR_W-1:0] sw_eff, sh_eff;
	logic [sbsr_pkg::SPR_W-1:0] pw_eff, ph_eff;

	// Request and walk state
	sbsr_pkg::req_t                  req_q;
	logic [sbsr_pkg::FB_AW-1:0]      init_q;
	logic [sbsr_pkg::FB_AW-1:0]      fb_q, fb_row_q;
	logic [sbsr_pkg::SAVE_AW-1:0]    bit_q, row_bit_q;
	logic [sbsr_pkg::SPR_W-1:0]      c_q, r_q, cols_q, rows_q;
	logic [sbsr_pkg::PIXEL_W-1:0]    res_pixel_q;
	logic                            res_oor_q;
	logic                            out_valid_q;
	sbsr_pkg::res_t                  out_res_q;

	// Setup arithmetic
	logic [sbsr_pkg::PROD_W-1:0] at_full;
	logic [sbsr_pkg::SCR_W-1:0]  x9, y9, span_x, span_y;
	logic [sbsr_pkg::SPR_W-1:0]  cols_d, rows_d;
	logic                        pix_off, walk_off;

	// Walk control
	logic [sbsr_pkg::SPR_W-1:0] c_inc, r_inc;
	logic                       last_col, last_row, mask_set, is_draw;

	// RAM ports
	logic                               fb_we;
	logic [sbsr_pkg::FB_AW-1:0]         fb_waddr;
	logic [sbsr_pkg::PIXEL_W-1:0]       fb_wdata, fb_rdata;
	logic                               mask_we;
	logic [sbsr_pkg::BITS_PER_BYTE-1:0] mask_rdata;
	logic [sbsr_pkg::MASK_AW-1:0]       mask_raddr;
	logic                               save_we;
	logic [sbsr_pkg::PIXEL_W-1:0]       saved_rdata, drawn_rdata;

	// Clamp config to the store sizes
	always_comb begin
		sw_eff = (sw_q > sbsr_pkg::SCR_W'(sbsr_pkg::MAX_SCREEN_WIDTH)) ?
			sbsr_pkg::SCR_W'(sbsr_pkg::MAX_SCREEN_WIDTH) : sw_q;
		sh_eff = (sh_q > sbsr_pkg::SCR_W'(sbsr_pkg::MAX_SCREEN_HEIGHT)) ?
			sbsr_pkg::SCR_W'(sbsr_pkg::MAX_SCREEN_HEIGHT) : sh_q;
		pw_eff = (pw_q > sbsr_pkg::SPR_W'(sbsr_pkg::MAX_SPRITE_SIDE)) ?
			sbsr_pkg::SPR_W'(sbsr_pkg::MAX_SPRITE_SIDE) : pw_q;
		ph_eff = (ph_q > sbsr_pkg::SPR_W'(sbsr_pkg::MAX_SPRITE_SIDE)) ?
			sbsr_pkg::SPR_W'(sbsr_pkg::MAX_SPRITE_SIDE) : ph_q;
	end

	// Pixel address and sprite clipping for the held request
	always_comb begin
		x9 = sbsr_pkg::SCR_W'(req_q.x_coord);
		y9 = sbsr_pkg::SCR_W'(req_q.y_coord);
		at_full = sbsr_pkg::PROD_W'(req_q.y_coord) * sbsr_pkg::PROD_W'(sw_eff)
			+ sbsr_pkg::PROD_W'(req_q.x_coord);
		walk_off = (x9 >= sw_eff) || (y9 >= sh_eff);
		pix_off = walk_off || (at_full >= sbsr_pkg::PROD_W'(sbsr_pkg::FB_DEPTH));
		span_x = sw_eff - x9;
		span_y = sh_eff - y9;
		cols_d = (sbsr_pkg::SCR_W'(pw_eff) < span_x) ? pw_eff : span_x[sbsr_pkg::SPR_W-1:0];
		rows_d = (sbsr_pkg::SCR_W'(ph_eff) < span_y) ? ph_eff : span_y[sbsr_pkg::SPR_W-1:0];
	end

	// Walk step decode
	always_comb begin
		c_inc = c_q + sbsr_pkg::SPR_W'(1);
		r_inc = r_q + sbsr_pkg::SPR_W'(1);
		last_col = (c_inc == cols_q);
		last_row = (r_inc == rows_q);
		mask_set = (mask_rdata & (sbsr_pkg::MASK_FIRST_BIT >>
			bit_q[sbsr_pkg::BYTE_SHIFT-1:0])) != '0;
		is_draw = (req_q.kind == sbsr_pkg::KIND_DRAW);
	end

	// Frame and save store write controls
	always_comb begin
		fb_we = 1'b0;
		fb_waddr = fb_q;
		fb_wdata = req_q.color;
		save_we = 1'b0;
		case (state_q)
			S_INIT: begin
				fb_we = 1'b1;
				fb_waddr = init_q;
				fb_wdata = '0;
			end
			S_ACCESS: begin
				fb_we = (req_q.kind == sbsr_pkg::KIND_WRITE);
			end
			S_APPLY: begin
				if (is_draw) begin
					fb_we = mask_set;
					save_we = mask_set;
				end else begin
					fb_we = mask_set && (fb_rdata == drawn_rdata);
					fb_wdata = saved_rdata;
				end
			end
			default: begin
				fb_we = 1'b0;
			end
		endcase
	end

	assign mask_we = (state_q == S_SETUP) && (req_q.kind == sbsr_pkg::KIND_LOAD) &&
		(sbsr_pkg::MIDX_W'(req_q.mask_index) < sbsr_pkg::MIDX_W'(sbsr_pkg::MASK_DEPTH - 1)
		|| req_q.mask_index == sbsr_pkg::MIDX_W'(sbsr_pkg::MASK_DEPTH - 1));
	assign mask_raddr = bit_q[sbsr_pkg::SAVE_AW-1:sbsr_pkg::BYTE_SHIFT];

	// Config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sw_q <= sbsr_pkg::SCR_W'(sbsr_pkg::MAX_SCREEN_WIDTH);
			sh_q <= sbsr_pkg::SCR_W'(sbsr_pkg::MAX_SCREEN_HEIGHT);
			pw_q <= sbsr_pkg::SPR_W'(sbsr_pkg::MAX_SPRITE_SIDE);
			ph_q <= sbsr_pkg::SPR_W'(sbsr_pkg::MAX_SPRITE_SIDE);
		end else if (cfg_we) begin
			case (cfg_index)
				sbsr_pkg::CFG_SCREEN_WIDTH:  sw_q <= cfg_data;
				sbsr_pkg::CFG_SCREEN_HEIGHT: sh_q <= cfg_data;
				sbsr_pkg::CFG_SPRITE_WIDTH:  pw_q <= cfg_data[sbsr_pkg::SPR_W-1:0];
				sbsr_pkg::CFG_SPRITE_HEIGHT: ph_q <= cfg_data[sbsr_pkg::SPR_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			init_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// drop the result once taken, unless the result state reloads it
			if (out_valid_q && !out_stall && state_q != S_RESULT) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_INIT: begin
					init_q <= init_q + sbsr_pkg::FB_AW'(1);
					if (init_q == sbsr_pkg::FB_AW'(sbsr_pkg::FB_DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						req_q <= in_data;
						state_q <= S_SETUP;
					end
				end
				S_SETUP: begin
					res_pixel_q <= '0;
					res_oor_q <= 1'b0;
					fb_q <= at_full[sbsr_pkg::FB_AW-1:0];
					fb_row_q <= at_full[sbsr_pkg::FB_AW-1:0];
					bit_q <= '0;
					row_bit_q <= '0;
					c_q <= '0;
					r_q <= '0;
					cols_q <= cols_d;
					rows_q <= rows_d;
					state_q <= S_RESULT;
					case (req_q.kind)
						sbsr_pkg::KIND_DRAW, sbsr_pkg::KIND_CLEAR: begin
							if (!walk_off && cols_d != '0 && rows_d != '0) begin
								state_q <= S_FETCH;
							end
						end
						sbsr_pkg::KIND_WRITE, sbsr_pkg::KIND_READ: begin
							if (pix_off) begin
								res_oor_q <= 1'b1;
							end else begin
								state_q <= S_ACCESS;
							end
						end
						default: begin
						end
					endcase
				end
				S_ACCESS: begin
					state_q <= (req_q.kind == sbsr_pkg::KIND_READ) ? S_READ : S_RESULT;
				end
				S_READ: begin
					res_pixel_q <= fb_rdata;
					state_q <= S_RESULT;
				end
				S_FETCH: begin
					state_q <= S_APPLY;
				end
				S_APPLY: begin
					// advance column, then row, else finish
					state_q <= S_FETCH;
					if (!last_col) begin
						c_q <= c_inc;
						bit_q <= bit_q + sbsr_pkg::SAVE_AW'(1);
						fb_q <= fb_q + sbsr_pkg::FB_AW'(1);
					end else if (!last_row) begin
						c_q <= '0;
						r_q <= r_inc;
						row_bit_q <= row_bit_q + sbsr_pkg::SAVE_AW'(pw_eff);
						bit_q <= row_bit_q + sbsr_pkg::SAVE_AW'(pw_eff);
						fb_row_q <= fb_row_q + sbsr_pkg::FB_AW'(sw_eff);
						fb_q <= fb_row_q + sbsr_pkg::FB_AW'(sw_eff);
					end else begin
						state_q <= S_RESULT;
					end
				end
				S_RESULT: begin
					if (!out_valid_q || !out_stall) begin
						out_res_q.pixel_value <= res_pixel_q;
						out_res_q.out_of_range <= res_oor_q;
						out_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_stall = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data = out_res_q;

	// Framebuffer
	sbsr_ram #(
		.WIDTH(sbsr_pkg::PIXEL_W),
		.DEPTH(sbsr_pkg::FB_DEPTH)
	) u_frame (
		.clk(clk),
		.we(fb_we),
		.waddr(fb_waddr),
		.wdata(fb_wdata),
		.raddr(fb_q),
		.rdata(fb_rdata)
	);

	// Sprite mask
	sbsr_ram #(
		.WIDTH(sbsr_pkg::BITS_PER_BYTE),
		.DEPTH(sbsr_pkg::MASK_DEPTH)
	) u_mask (
		.clk(clk),
		.we(mask_we),
		.waddr(req_q.mask_index[sbsr_pkg::MASK_AW-1:0]),
		.wdata(req_q.mask_byte),
		.raddr(mask_raddr),
		.rdata(mask_rdata)
	);

	// Saved background
	sbsr_ram #(
		.WIDTH(sbsr_pkg::PIXEL_W),
		.DEPTH(sbsr_pkg::SAVE_DEPTH)
	) u_saved (
		.clk(clk),
		.we(save_we),
		.waddr(bit_q),
		.wdata(fb_rdata),
		.raddr(bit_q),
		.rdata(saved_rdata)
	);

	// Drawn values
	sbsr_ram #(
		.WIDTH(sbsr_pkg::PIXEL_W),
		.DEPTH(sbsr_pkg::SAVE_DEPTH)
	) u_drawn (
		.clk(clk),
		.we(save_we),
		.waddr(bit_q),
		.wdata(req_q.color),
		.raddr(bit_q),
		.rdata(drawn_rdata)
	);

`ifndef NO_ASSERTIONS
	// A new result appears only out of the result state
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_RESULT))
		else $error("result loaded outside result state");

	// The walk stays inside the clipped sprite
	a_walk_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_APPLY) |-> (c_q < cols_q && r_q < rows_q))
		else $error("walk left the clipped sprite");

	// An accepted request closes the input until it is done
	a_one_request: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input open right after a request");
`endif

endmodule

[rtl/sbsr_ram.sv]
// Generic one-write, one-read RAM with registered read data.
// No dependencies.
module sbsr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule
